/* rtl/core/psd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    // Fixed field widths of the point and distance channels.
    localparam int COORD_WIDTH = 16;
    localparam int NUM_COORDS  = 8;
    localparam int INDEX_WIDTH = 6;
    localparam int DIST_WIDTH  = 2 * COORD_WIDTH + 3;
    localparam int DIMS_WIDTH  = 4;
    localparam logic [DIMS_WIDTH-1:0] DIMS_RESET = 4'd8;

    // One incoming point request.
    typedef struct packed {
        logic                          start_set;
        logic signed [COORD_WIDTH-1:0] coord_0;
        logic signed [COORD_WIDTH-1:0] coord_1;
        logic signed [COORD_WIDTH-1:0] coord_2;
        logic signed [COORD_WIDTH-1:0] coord_3;
        logic signed [COORD_WIDTH-1:0] coord_4;
        logic signed [COORD_WIDTH-1:0] coord_5;
        logic signed [COORD_WIDTH-1:0] coord_6;
        logic signed [COORD_WIDTH-1:0] coord_7;
    } point_in_t;

    // One outgoing distance request.
    typedef struct packed {
        logic [INDEX_WIDTH-1:0] earlier_index;
        logic [INDEX_WIDTH-1:0] new_index;
        logic [DIST_WIDTH-1:0]  sq_distance;
        logic                   last_of_run;
    } dist_out_t;

    // Work handed from the front end to the distance engine.
    typedef struct packed {
        logic [INDEX_WIDTH-1:0]                  new_index;
        logic [NUM_COORDS-1:0][COORD_WIDTH-1:0]  coords;
    } point_cmd_t;

    typedef struct packed {
        logic       valid;
        point_cmd_t cmd;
    } push_t;

endpackage

`default_nettype wire

/* rtl/core/psd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module psd_front #(
    parameter int MAX_POINTS = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               point_valid,
    output logic                    point_stall,
    input  wire psd_pkg::point_in_t point,
    input  wire logic               q_full,
    output psd_pkg::push_t          push
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] cnt_eff;
    logic             accept;
    logic             room;

    assign point_stall = q_full;
    assign accept      = point_valid && !q_full;

    // A start flag restarts the set before the capacity check.
    assign cnt_eff = point.start_set ? '0 : count_reg;
    assign room    = cnt_eff < CNT_W'(MAX_POINTS);

    always_comb
    begin
        push.valid           = accept && room;
        push.cmd.new_index   = psd_pkg::INDEX_WIDTH'(cnt_eff);
        push.cmd.coords[0]   = point.coord_0;
        push.cmd.coords[1]   = point.coord_1;
        push.cmd.coords[2]   = point.coord_2;
        push.cmd.coords[3]   = point.coord_3;
        push.cmd.coords[4]   = point.coord_4;
        push.cmd.coords[5]   = point.coord_5;
        push.cmd.coords[6]   = point.coord_6;
        push.cmd.coords[7]   = point.coord_7;
        count_next           = count_reg;
        if (accept && room)
        begin
            count_next = cnt_eff + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/psd_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module psd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire psd_pkg::push_t      push,
    input  wire logic                pop,
    output logic                     full,
    output logic                     q_valid,
    output psd_pkg::point_cmd_t      head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    psd_pkg::point_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;

    assign full    = fill_reg == CNT_W'(DEPTH);
    assign q_valid = fill_reg != '0;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push.valid && !(pop && q_valid))
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (!push.valid && pop && q_valid)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push.valid)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop && q_valid)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/psd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module psd_back #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIMS   = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [psd_pkg::DIMS_WIDTH-1:0]    dims,
    input  wire logic                              q_valid,
    input  wire psd_pkg::point_cmd_t               head,
    output logic                                   pop,
    output logic                                   dist_valid,
    input  wire logic                              dist_stall,
    output psd_pkg::dist_out_t                     distance
);

    localparam int CW        = psd_pkg::COORD_WIDTH;
    localparam int IW        = psd_pkg::INDEX_WIDTH;
    localparam int DW        = psd_pkg::DIST_WIDTH;
    localparam int IDX_W     = $clog2(MAX_POINTS);
    localparam int NUM_PAIRS = (MAX_DIMS + 1) / 2;
    localparam int LANES     = 2 * NUM_PAIRS;
    localparam int SQ_W      = 2 * CW;
    localparam int PAIR_W    = SQ_W + 1;

    typedef struct packed {
        logic [IW-1:0] earlier_index;
        logic [IW-1:0] new_index;
        logic          last_of_run;
    } tag_t;

    // Point store: one row holds every coordinate of one point.
    logic [MAX_DIMS-1:0][CW-1:0] mem [MAX_POINTS];

    logic [IDX_W-1:0] rd_idx_reg;
    logic             adv;
    logic             is_first;
    logic             last_rd;
    logic             rd_fire;

    logic                        s1_valid_reg;
    logic [MAX_DIMS-1:0][CW-1:0] row_reg;
    logic [MAX_DIMS-1:0][CW-1:0] s1_pt_reg;
    tag_t                        s1_tag_reg;

    logic             s2_valid_reg;
    logic [CW-1:0]    abs_reg  [LANES];
    logic [CW-1:0]    abs_next [LANES];
    logic signed [CW:0] diff   [MAX_DIMS];
    tag_t             s2_tag_reg;

    logic             s3_valid_reg;
    logic [SQ_W-1:0]  sq_reg  [LANES];
    logic [SQ_W-1:0]  sq_next [LANES];
    tag_t             s3_tag_reg;

    logic              s4_valid_reg;
    logic [PAIR_W-1:0] pair_reg  [NUM_PAIRS];
    logic [PAIR_W-1:0] pair_next [NUM_PAIRS];
    tag_t              s4_tag_reg;

    logic                dist_valid_reg;
    psd_pkg::dist_out_t  dist_reg;
    logic [DW-1:0]       sum_next;

    // The whole pipeline moves when the output register is free or drained.
    assign adv      = !dist_valid_reg || !dist_stall;
    assign is_first = head.new_index == '0;
    assign last_rd  = (IW'(rd_idx_reg) + IW'(1)) == head.new_index;
    assign rd_fire  = q_valid && !is_first && adv;
    assign pop      = q_valid && (is_first || (adv && last_rd));

    assign dist_valid = dist_valid_reg;
    assign distance   = dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
        end
        else if (pop)
        begin
            rd_idx_reg <= '0;
        end
        else if (rd_fire)
        begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // The new point is written when its request leaves the queue, with its last
    // earlier row read if it has one, so the next request always sees it.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mem[head.new_index[IDX_W-1:0]] <= head.coords[MAX_DIMS-1:0];
        end
        if (rd_fire)
        begin
            row_reg                  <= mem[rd_idx_reg];
            s1_pt_reg                <= head.coords[MAX_DIMS-1:0];
            s1_tag_reg.earlier_index <= IW'(rd_idx_reg);
            s1_tag_reg.new_index     <= head.new_index;
            s1_tag_reg.last_of_run   <= last_rd;
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            abs_next[k] = '0;
        end
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            diff[k] = $signed({row_reg[k][CW-1], row_reg[k]})
                    - $signed({s1_pt_reg[k][CW-1], s1_pt_reg[k]});
            if (psd_pkg::DIMS_WIDTH'(k) < dims)
            begin
                abs_next[k] = diff[k][CW] ? CW'(-diff[k]) : CW'(diff[k]);
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sq_next[k] = abs_reg[k] * abs_reg[k];
        end
        for (int j = 0; j < NUM_PAIRS; j++)
        begin
            pair_next[j] = PAIR_W'(sq_reg[2 * j]) + PAIR_W'(sq_reg[2 * j + 1]);
        end
        sum_next = '0;
        for (int j = 0; j < NUM_PAIRS; j++)
        begin
            sum_next = sum_next + DW'(pair_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            abs_reg    <= abs_next;
            s2_tag_reg <= s1_tag_reg;
            sq_reg     <= sq_next;
            s3_tag_reg <= s2_tag_reg;
            pair_reg   <= pair_next;
            s4_tag_reg <= s3_tag_reg;
            dist_reg.earlier_index <= s4_tag_reg.earlier_index;
            dist_reg.new_index     <= s4_tag_reg.new_index;
            dist_reg.last_of_run   <= s4_tag_reg.last_of_run;
            dist_reg.sq_distance   <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            dist_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg   <= rd_fire;
            s2_valid_reg   <= s1_valid_reg;
            s3_valid_reg   <= s2_valid_reg;
            s4_valid_reg   <= s3_valid_reg;
            dist_valid_reg <= s4_valid_reg;
        end
    end

`ifndef NO_ASSERTIONS
    // The read counter always points below the pending point's index.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !is_first |-> IW'(rd_idx_reg) < head.new_index)
        else $error("read index ran past the pending point");

    // With nothing queued the read counter is parked at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> rd_idx_reg == '0)
        else $error("read index not parked while idle");

    // The last distance of a run pairs the new point with its predecessor.
    assert property (@(posedge clk) disable iff (!rst_n)
        dist_valid_reg && dist_reg.last_of_run |->
            IW'(dist_reg.earlier_index + IW'(1)) == dist_reg.new_index)
        else $error("last_of_run on a pair that is not adjacent");

    // A request that has earlier points leaves the queue only on a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !is_first |-> rd_fire && last_rd)
        else $error("request retired without its final read");
`endif

endmodule

`default_nettype wire

/* rtl/core/pairwise_sq_distance_matrix.sv */
// Pairwise squared distance matrix, streamed by rows of the upper triangle.
// Each point request carries eight signed coordinates and a start_set flag
// that begins a new set. For every point the block returns one distance
// request per earlier point of the set (exact integer sum of squared
// coordinate differences over the first active_dims coordinates), tagged with
// both indexes and with last_of_run on the final one, then stores the point.
// The first point of a set produces no distances, and points past MAX_POINTS
// are dropped without any output. Distances come out at one per clock while
// the output is not stalled: a point with n earlier points takes n reads of
// the point store (none for the first point of a set), since its single read
// port delivers one stored point per cycle. A distance passes the row,
// difference, square, pair-sum and output registers after its read. A
// two-entry queue sits between the front end and the engine, so new points
// are taken while earlier ones are still being worked on. active_dims may
// be written only while the block is idle; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_sq_distance_matrix #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIMS   = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            point_valid,
    output logic                                 point_stall,
    input  wire psd_pkg::point_in_t              point,
    output logic                                 dist_valid,
    input  wire logic                            dist_stall,
    output psd_pkg::dist_out_t                   distance,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [psd_pkg::DIMS_WIDTH-1:0]  cfg_data
);

    logic [psd_pkg::DIMS_WIDTH-1:0] active_dims_reg;
    logic [psd_pkg::DIMS_WIDTH-1:0] used_dims;

    psd_pkg::push_t      push;
    psd_pkg::point_cmd_t head;
    logic                q_full;
    logic                q_valid;
    logic                pop;

    // The configuration register can always be written.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dims_reg <= psd_pkg::DIMS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            active_dims_reg <= cfg_data;
        end
    end

    // Zero counts as one dimension, and anything past MAX_DIMS as MAX_DIMS.
    always_comb
    begin
        if (active_dims_reg == '0)
        begin
            used_dims = psd_pkg::DIMS_WIDTH'(1);
        end
        else if (active_dims_reg > psd_pkg::DIMS_WIDTH'(MAX_DIMS))
        begin
            used_dims = psd_pkg::DIMS_WIDTH'(MAX_DIMS);
        end
        else
        begin
            used_dims = active_dims_reg;
        end
    end

    // The front end tracks the set size and decides which points are kept.
    psd_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .q_full      (q_full),
        .push        (push)
    );

    psd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .q_valid (q_valid),
        .head    (head)
    );

    // The engine walks the earlier points and runs the distance pipeline.
    psd_back #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .dims       (used_dims),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .dist_valid (dist_valid),
        .dist_stall (dist_stall),
        .distance   (distance)
    );

endmodule

`default_nettype wire

/* bench/tb_pairwise_sq_distance_matrix.sv */
`timescale 1ns / 1ps

// Self-checking bench for the pairwise squared distance block.
//
// Point requests go in on a valid/stall channel; every accepted point is run
// through a behavioral predictor that keeps its own copy of the current set.
// The predictor appends one expected distance request per earlier stored
// point to a queue. A monitor pops that queue on every accepted distance
// request and compares all four fields. The active_dims register is only
// written when the block has drained, followed by a short settling pause.
// Point requests that cause no distances can still be in flight at that time.
module tb_pairwise_sq_distance_matrix;

    localparam int SET_CAPACITY            = 64;
    localparam int DIMS_MAX                = 8;
    // Covers the read-to-output pipeline plus the two-entry point queue.
    localparam int DRAIN_CYCLES            = 20;
    // Long enough for the point queue and the pipeline to fill completely.
    localparam int HOLD_CYCLES             = 300;
    localparam int RANDOM_POINTS_PER_PHASE = 105;

    localparam int CWID = psd_pkg::COORD_WIDTH;
    localparam int NC   = psd_pkg::NUM_COORDS;
    localparam int DWID = psd_pkg::DIMS_WIDTH;

    localparam logic signed [CWID-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [CWID-1:0] COORD_MAX = 16'sh7fff;

    // Shapes of random points: anywhere in range, at the corners of the
    // range, or clustered near the origin so that distances stay small.
    typedef enum int {
        COORD_FULL,
        COORD_EXTREME,
        COORD_SMALL
    } coord_style_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 point_valid = 1'b0;
    logic                 point_stall;
    psd_pkg::point_in_t   point       = '0;
    logic                 dist_valid;
    logic                 dist_stall  = 1'b0;
    psd_pkg::dist_out_t   distance;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [DWID-1:0]      cfg_data    = '0;

    // Predictor state: the points of the current set and the effective
    // number of summed coordinates after clamping the register to 1..8.
    logic signed [CWID-1:0] stored_coords [SET_CAPACITY][NC];
    int unsigned            set_size     = 0;
    int unsigned            summed_dims  = psd_pkg::DIMS_RESET;
    psd_pkg::dist_out_t     expected_dists[$];

    int   errors        = 0;
    int   points_stored = 0;
    int   tx_idle_pct   = 0;
    int   rx_idle_pct   = 0;
    logic rx_hold       = 1'b0;
    event hold_request;

    pairwise_sq_distance_matrix u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .dist_valid  (dist_valid),
        .dist_stall  (dist_stall),
        .distance    (distance),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Coordinate k sits in the packed point below start_set, coord_0 first.
    function automatic logic signed [CWID-1:0] coord_at(psd_pkg::point_in_t p, int k);
        return p[(NC - 1 - k) * CWID +: CWID];
    endfunction

    function automatic psd_pkg::point_in_t flat_point(bit start,
                                                      logic signed [CWID-1:0] v);
        return psd_pkg::point_in_t'({start, {NC{v}}});
    endfunction

    function automatic psd_pkg::point_in_t rand_point(bit start);
        psd_pkg::point_in_t p;
        coord_style_t       style;
        style = coord_style_t'($urandom_range(0, 2));
        p = '0;
        p.start_set = start;
        for (int k = 0; k < NC; k++)
        begin
            case (style)
                COORD_FULL:
                    p[(NC - 1 - k) * CWID +: CWID] = CWID'($urandom);
                COORD_EXTREME:
                    case ($urandom_range(0, 3))
                        0: p[(NC - 1 - k) * CWID +: CWID] = COORD_MIN;
                        1: p[(NC - 1 - k) * CWID +: CWID] = COORD_MAX;
                        2: p[(NC - 1 - k) * CWID +: CWID] = '0;
                        default: p[(NC - 1 - k) * CWID +: CWID] = '1;
                    endcase
                default:
                    p[(NC - 1 - k) * CWID +: CWID] =
                        CWID'($urandom_range(0, 200) - 100);
            endcase
        end
        return p;
    endfunction

    // Works out the distance requests that one accepted point causes and
    // then adds the point to the set. Returns 1 if the point was stored,
    // 0 if the set was already full and the point is dropped.
    function automatic bit predict_distances(psd_pkg::point_in_t p);
        longint             sum;
        longint             diff;
        psd_pkg::dist_out_t d;
        if (p.start_set)
            set_size = 0;
        if (set_size >= SET_CAPACITY)
            return 1'b0;
        for (int i = 0; i < set_size; i++)
        begin
            sum = 0;
            for (int k = 0; k < summed_dims; k++)
            begin
                diff = longint'(stored_coords[i][k]) - longint'(coord_at(p, k));
                sum += diff * diff;
            end
            d.earlier_index = i[psd_pkg::INDEX_WIDTH-1:0];
            d.new_index     = set_size[psd_pkg::INDEX_WIDTH-1:0];
            d.sq_distance   = sum[psd_pkg::DIST_WIDTH-1:0];
            d.last_of_run   = (i + 1 == set_size);
            expected_dists.push_back(d);
        end
        for (int k = 0; k < NC; k++)
            stored_coords[set_size][k] = coord_at(p, k);
        set_size++;
        return 1'b1;
    endfunction

    // Offers one point request and waits for it to be taken. Valid stays
    // high afterwards so that a following call can reuse the same cycle;
    // with the sender's idle probability it drops valid for a random gap.
    task automatic send_point(psd_pkg::point_in_t p);
        point       <= p;
        point_valid <= 1'b1;
        do @(posedge clk); while (point_stall);
        if (predict_distances(p))
            points_stored++;
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            point_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    // Stops offering points and waits until every predicted distance has
    // come out, then gives the block time to retire points without results.
    task automatic wait_idle();
        point_valid <= 1'b0;
        do @(posedge clk); while (expected_dists.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes active_dims; the block must be idle. The predictor applies the
    // same saturation to 1..8 that the block uses.
    task automatic write_active_dims(logic [DWID-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value < 1)
            summed_dims = 1;
        else if (value > DIMS_MAX)
            summed_dims = DIMS_MAX;
        else
            summed_dims = value;
        @(posedge clk);
    endtask

    // Corner points at reset width: the largest possible distance between
    // the two opposite corners, identical points giving zero, and single
    // point sets that must produce no distances at all.
    task automatic test_extreme_points();
        send_point(flat_point(1'b1, COORD_MIN));
        send_point(flat_point(1'b0, COORD_MAX));
        send_point(flat_point(1'b0, '0));
        send_point(psd_pkg::point_in_t'({1'b0, COORD_MAX, COORD_MIN, COORD_MAX,
                                         COORD_MIN, COORD_MAX, COORD_MIN,
                                         COORD_MAX, COORD_MIN}));
        send_point(flat_point(1'b0, '1));
        send_point(flat_point(1'b1, COORD_MAX));
        send_point(flat_point(1'b0, COORD_MAX));
        send_point(flat_point(1'b1, '0));
        send_point(flat_point(1'b1, 16'sd1));
        wait_idle();
    endtask

    // Register values at and beyond both ends of the legal range: zero must
    // act as one dimension and anything above eight as eight.
    task automatic test_dims_saturation();
        logic [DWID-1:0] dims_values [4] = '{4'd0, 4'd1, 4'd15, 4'd8};
        foreach (dims_values[n])
        begin
            write_active_dims(dims_values[n]);
            send_point(flat_point(1'b1, COORD_MIN));
            send_point(flat_point(1'b0, COORD_MAX));
            send_point(rand_point(1'b0));
            wait_idle();
        end
    endtask

    // Fills the set to capacity, offers a few more points that must be
    // dropped without output, then restarts the set with start_set.
    task automatic test_set_capacity();
        for (int j = 0; j < SET_CAPACITY + 3; j++)
            send_point(rand_point(j == 0));
        send_point(rand_point(1'b1));
        send_point(rand_point(1'b0));
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back-to-back points, so the block backs up and stalls input.
    task automatic test_output_holdoff();
        tx_idle_pct = 0;
        -> hold_request;
        for (int j = 0; j < 16; j++)
            send_point(rand_point(j == 0));
        wait_idle();
    endtask

    // Random sets of random size. Most are clean sets opened by start_set;
    // a few start without the flag (extending the previous set) or restart
    // midway, and a few overrun capacity. The width is changed now and then
    // once the block has drained.
    task automatic run_random_sets(int tx_pct, int rx_pct);
        int base;
        int set_len;
        int choice;
        bit start;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        base = points_stored;
        while (points_stored - base < RANDOM_POINTS_PER_PHASE)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                wait_idle();
                write_active_dims(DWID'($urandom_range(0, 15)));
            end
            choice = $urandom_range(0, 99);
            if (choice < 4)
                set_len = SET_CAPACITY + $urandom_range(1, 3);
            else if (choice < 80)
                set_len = $urandom_range(2, 10);
            else
                set_len = $urandom_range(1, 24);
            for (int j = 0; j < set_len; j++)
            begin
                if (j == 0)
                    start = ($urandom_range(0, 19) != 0);
                else
                    start = ($urandom_range(0, 49) == 0);
                send_point(rand_point(start));
            end
        end
        wait_idle();
    endtask

    // Receiver side: random stalls, plus the long hold-off stretch.
    always @(posedge clk)
        dist_stall <= rx_hold || ($urandom_range(0, 99) < rx_idle_pct);

    initial
    begin
        forever
        begin
            @(hold_request);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    function automatic void check_field(string field_name, logic [63:0] want,
                                        logic [63:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, want, got);
        end
    endfunction

    // Every accepted distance request is matched against the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin
        psd_pkg::dist_out_t want;
        if (rst_n && dist_valid && !dist_stall)
        begin
            if (expected_dists.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected distance request, expected none, actual %p",
                         $time, distance);
            end
            else
            begin
                want = expected_dists.pop_front();
                check_field("earlier_index", 64'(want.earlier_index),
                            64'(distance.earlier_index));
                check_field("new_index", 64'(want.new_index), 64'(distance.new_index));
                check_field("sq_distance", 64'(want.sq_distance),
                            64'(distance.sq_distance));
                check_field("last_of_run", 64'(want.last_of_run),
                            64'(distance.last_of_run));
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 9;
        rx_idle_pct = 30;
        test_extreme_points();
        test_dims_saturation();
        test_set_capacity();
        test_output_holdoff();

        run_random_sets(9, 79);
        run_random_sets(79, 9);
        run_random_sets(0, 0);

        if (errors == 0)
            $display("pairwise_sq_distance_matrix regression: pass");
        else
            $display("pairwise_sq_distance_matrix regression: fail");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #20ms;
        $display("pairwise_sq_distance_matrix regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/core/psd_pkg.sv
rtl/core/psd_front.sv
rtl/core/psd_queue.sv
rtl/core/psd_back.sv
rtl/core/pairwise_sq_distance_matrix.sv
bench/tb_pairwise_sq_distance_matrix.sv
